// ----- rtl/pnmp_pkg.sv -----
package pnmp_pkg;

  localparam int DATA_W = 64;
  localparam int HALF_W = 32;
  localparam int ELEMS  = 9;

  typedef logic [DATA_W-1:0] word_t;
  typedef logic [HALF_W-1:0] half_t;
  typedef logic [3:0]        elem_t;
  typedef logic [1:0]        coord_t;
  typedef logic [2:0]        step_t;

  typedef enum logic [2:0] {
    OP_LOAD    = 3'd0,
    OP_NOP     = 3'd1,
    OP_MUL_ACC = 3'd2,
    OP_MUL_SQ  = 3'd3,
    OP_SHIFT   = 3'd4,
    OP_DOT     = 3'd5,
    OP_EMIT    = 3'd6
  } op_t;

  typedef enum logic [2:0] {
    CD_NEXT     = 3'd0,
    CD_ALWAYS   = 3'd1,
    CD_SMALL    = 3'd2,
    CD_BIT0_CLR = 3'd3,
    CD_EXP_ZERO = 3'd4
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t target;
  } uword_t;

  typedef struct packed {
    logic in_valid;
    logic mm_done;
    logic out_free;
    logic small_idx;
    logic bit0;
    logic exp_zero;
  } status_t;

  localparam step_t ST_LOAD  = 3'd0;
  localparam step_t ST_TEST  = 3'd1;
  localparam step_t ST_MACC  = 3'd2;
  localparam step_t ST_SHIFT = 3'd3;
  localparam step_t ST_CHK   = 3'd4;
  localparam step_t ST_MSQ   = 3'd5;
  localparam step_t ST_DOT   = 3'd6;
  localparam step_t ST_EMIT  = 3'd7;

  localparam word_t P0 = 64'd3;
  localparam word_t P1 = 64'd0;
  localparam word_t P2 = 64'd2;

  localparam coord_t LAST_COORD = 2'd2;
  localparam coord_t PH_LO_LO   = 2'd0;
  localparam coord_t PH_LO_HI   = 2'd1;
  localparam coord_t PH_HI_LO   = 2'd2;

  localparam word_t COMPANION [ELEMS] = '{
    64'd0, 64'd1, 64'd1,
    64'd1, 64'd0, 64'd0,
    64'd0, 64'd1, 64'd0
  };

  localparam word_t IDENTITY [ELEMS] = '{
    64'd1, 64'd0, 64'd0,
    64'd0, 64'd1, 64'd0,
    64'd0, 64'd0, 64'd1
  };

  // Square-and-multiply program, exponent LSB first.
  function automatic uword_t ucode(step_t s);
    uword_t w;
    case (s)
      ST_LOAD:  w = '{op: OP_LOAD,    cond: CD_SMALL,    target: ST_EMIT};
      ST_TEST:  w = '{op: OP_NOP,     cond: CD_BIT0_CLR, target: ST_SHIFT};
      ST_MACC:  w = '{op: OP_MUL_ACC, cond: CD_NEXT,     target: ST_LOAD};
      ST_SHIFT: w = '{op: OP_SHIFT,   cond: CD_NEXT,     target: ST_LOAD};
      ST_CHK:   w = '{op: OP_NOP,     cond: CD_EXP_ZERO, target: ST_DOT};
      ST_MSQ:   w = '{op: OP_MUL_SQ,  cond: CD_ALWAYS,   target: ST_TEST};
      ST_DOT:   w = '{op: OP_DOT,     cond: CD_NEXT,     target: ST_LOAD};
      ST_EMIT:  w = '{op: OP_EMIT,    cond: CD_ALWAYS,   target: ST_LOAD};
      default:  w = '{op: OP_NOP,     cond: CD_ALWAYS,   target: ST_LOAD};
    endcase
    return w;
  endfunction

  function automatic word_t small_value(logic [1:0] n);
    word_t v;
    case (n)
      2'd0:    v = P0;
      2'd1:    v = P1;
      default: v = P2;
    endcase
    return v;
  endfunction

  function automatic elem_t elem_idx(coord_t r, coord_t c);
    return elem_t'({2'b00, r} * 4'd3) + elem_t'({2'b00, c});
  endfunction

endpackage

// ----- rtl/pnmp_seq.sv -----
module pnmp_seq
  import pnmp_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  status_t stat,
  output uword_t  uw,
  output logic    adv
);

  step_t step;
  step_t step_next;
  logic  jump;

  assign uw = ucode(step);

  always_comb begin
    case (uw.op)
      OP_LOAD:    adv = stat.in_valid;
      OP_MUL_ACC: adv = stat.mm_done;
      OP_MUL_SQ:  adv = stat.mm_done;
      OP_EMIT:    adv = stat.out_free;
      default:    adv = 1'b1;
    endcase
  end

  always_comb begin
    case (uw.cond)
      CD_NEXT:     jump = 1'b0;
      CD_ALWAYS:   jump = 1'b1;
      CD_SMALL:    jump = stat.small_idx;
      CD_BIT0_CLR: jump = !stat.bit0;
      CD_EXP_ZERO: jump = stat.exp_zero;
      default:     jump = 1'b0;
    endcase
  end

  always_comb begin
    step_next = step;
    if (adv) begin
      step_next = jump ? uw.target : step + step_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= ST_LOAD;
    end else begin
      step <= step_next;
    end
  end

endmodule

// ----- rtl/pnmp_matmul.sv -----
module pnmp_matmul
  import pnmp_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  init,
  input  logic  start,
  input  logic  dst_sq,
  output logic  busy,
  output logic  done,
  output word_t acc00,
  output word_t acc02
);

  word_t acc  [ELEMS];
  word_t sq   [ELEMS];
  word_t lmat [ELEMS];
  word_t rmat [ELEMS];
  logic  dst_reg;

  // issue stage counters
  logic   iss;
  coord_t ci, cj, ck, ph;
  logic   last_issue;

  // multiplier stage
  word_t  mp;
  logic   m_valid;
  logic   m_first;
  logic   m_last;
  elem_t  m_elem;
  coord_t m_ph;

  word_t sum;
  word_t term;
  word_t total;
  word_t a_op, b_op;
  half_t x_op, y_op;

  assign a_op = lmat[elem_idx(ci, ck)];
  assign b_op = rmat[elem_idx(ck, cj)];
  assign x_op = (ph == PH_HI_LO) ? a_op[DATA_W-1:HALF_W] : a_op[HALF_W-1:0];
  assign y_op = (ph == PH_LO_HI) ? b_op[DATA_W-1:HALF_W] : b_op[HALF_W-1:0];

  assign last_issue = (ci == LAST_COORD) && (cj == LAST_COORD) &&
                      (ck == LAST_COORD) && (ph == PH_HI_LO);

  // cross terms land in the upper half only, mod 2^64
  assign term  = (m_ph == PH_LO_LO) ? mp : {mp[HALF_W-1:0], {HALF_W{1'b0}}};
  assign total = m_first ? term : sum + term;

  assign busy  = iss | m_valid;
  assign done  = m_valid && m_last && (m_elem == elem_t'(ELEMS - 1));
  assign acc00 = acc[0];
  assign acc02 = acc[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      iss     <= 1'b0;
      m_valid <= 1'b0;
    end else begin
      m_valid <= iss;
      if (start) begin
        iss <= 1'b1;
      end else if (iss && last_issue) begin
        iss <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ci      <= '0;
      cj      <= '0;
      ck      <= '0;
      ph      <= PH_LO_LO;
      dst_reg <= dst_sq;
      for (int e = 0; e < ELEMS; e++) begin
        lmat[e] <= dst_sq ? sq[e] : acc[e];
        rmat[e] <= sq[e];
      end
    end else if (iss) begin
      if (ph != PH_HI_LO) begin
        ph <= ph + coord_t'(1);
      end else begin
        ph <= PH_LO_LO;
        if (ck != LAST_COORD) begin
          ck <= ck + coord_t'(1);
        end else begin
          ck <= '0;
          if (cj != LAST_COORD) begin
            cj <= cj + coord_t'(1);
          end else begin
            cj <= '0;
            ci <= ci + coord_t'(1);
          end
        end
      end
    end

    mp      <= x_op * y_op;
    m_first <= (ck == '0) && (ph == PH_LO_LO);
    m_last  <= (ck == LAST_COORD) && (ph == PH_HI_LO);
    m_elem  <= elem_idx(ci, cj);
    m_ph    <= ph;

    if (m_valid) begin
      sum <= total;
    end

    if (init) begin
      for (int e = 0; e < ELEMS; e++) begin
        acc[e] <= IDENTITY[e];
        sq[e]  <= COMPANION[e];
      end
    end else if (m_valid && m_last) begin
      if (dst_reg) begin
        sq[m_elem] <= total;
      end else begin
        acc[m_elem] <= total;
      end
    end
  end

endmodule

// ----- rtl/perrin_number_matrix_power_core.sv -----
// Perrin number P(n) by 3x3 companion matrix exponentiation, mod 2^64.
//
// Input channel: index with in_valid / in_stall. A word is taken when
// in_valid is high and in_stall is low. Only one index is in flight;
// in_stall stays high from the cycle after a take until the sequencer
// returns to its load step.
// Output channel: perrin_value with out_valid / out_stall, held in an
// output register, so the next index can be taken while a result waits.
//
// Indices 0, 1 and 2 go from the load step straight to the emit step.
// For larger n, e = n-2 is scanned LSB first: one multiply into the
// result for each set bit of e and one squaring between successive bits.
// Each 3x3 multiply issues 27 products, each split into three
// 32x32 partial products on one shared multiplier.
// Squarings past the top set bit of e are skipped.
//
// Reset (rst, synchronous) returns the sequencer to its load step and
// empties the output register. While out_stall is high the result holds
// and the sequencer waits at its emit step once the next result is ready.
module perrin_number_matrix_power_core
  import pnmp_pkg::*;
#(
  parameter int INDEX_BITS = 31
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [INDEX_BITS-1:0]  index,
  input  logic                   in_valid,
  output logic                   in_stall,
  output logic signed [63:0]     perrin_value,
  output logic                   out_valid,
  input  logic                   out_stall
);

  uword_t  uw;
  logic    adv;
  status_t stat;

  logic [INDEX_BITS-1:0] expo;
  word_t res;
  word_t dot;
  word_t acc00, acc02;
  logic  mm_busy, mm_done, mm_start;
  logic  take;
  logic  is_mul;

  assign in_stall = (uw.op != OP_LOAD);
  assign take     = in_valid && !in_stall;
  assign is_mul   = (uw.op == OP_MUL_ACC) || (uw.op == OP_MUL_SQ);
  assign mm_start = is_mul && !mm_busy;

  assign stat.in_valid  = in_valid;
  assign stat.mm_done   = mm_done;
  assign stat.out_free  = !out_valid || !out_stall;
  assign stat.small_idx = (index < INDEX_BITS'(3));
  assign stat.bit0      = expo[0];
  assign stat.exp_zero  = (expo == '0);

  // top row dotted with (2, 0, 3)
  assign dot = {acc00[DATA_W-2:0], 1'b0} + acc02 + {acc02[DATA_W-2:0], 1'b0};

  pnmp_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .uw   (uw),
    .adv  (adv)
  );

  pnmp_matmul u_mm (
    .clk    (clk),
    .rst    (rst),
    .init   (take),
    .start  (mm_start),
    .dst_sq (uw.op == OP_MUL_SQ),
    .busy   (mm_busy),
    .done   (mm_done),
    .acc00  (acc00),
    .acc02  (acc02)
  );

  always_ff @(posedge clk) begin
    if (take) begin
      expo <= index - INDEX_BITS'(2);
      res  <= small_value(index[1:0]);
    end else if (adv && uw.op == OP_SHIFT) begin
      expo <= expo >> 1;
    end else if (adv && uw.op == OP_DOT) begin
      res <= dot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv && uw.op == OP_EMIT) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && uw.op == OP_EMIT) begin
      perrin_value <= $signed(res);
    end
  end

endmodule

// ----- rtl/pnmp_checker.sv -----
module pnmp_checker #(
  parameter int INDEX_BITS = 31
) (
  input logic                  clk,
  input logic                  rst,
  input logic [INDEX_BITS-1:0] index,
  input logic                  in_valid,
  input logic                  in_stall,
  input logic signed [63:0]    perrin_value,
  input logic                  out_valid,
  input logic                  out_stall
);

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(perrin_value))
    else $error("result word changed under stall");

  a_rst_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output not empty after reset");

  // one index in flight at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second index taken back to back");

  a_index_zero: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && index == '0 && !out_valid
      |=> ##1 out_valid && perrin_value == 64'sd3)
    else $error("P(0) not delivered as 3");

endmodule

bind perrin_number_matrix_power_core pnmp_checker #(.INDEX_BITS(INDEX_BITS)) u_chk (.*);

// ----- bench/tb_perrin_number_matrix_power_core.sv -----
module tb_perrin_number_matrix_power_core;
  import pnmp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDX_W = 31;
  localparam int STUCK_LIMIT = 40000;
  localparam int TAIL_CYCLES = 100;
  localparam int MAX_REPORTS = 10;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [2:0][2:0][63:0] mat3_t;

  typedef struct packed {
    idx_t  n;
    word_t value;
  } perrin_expect_t;

  logic clk;
  logic rst;
  idx_t index;
  logic in_valid;
  logic in_stall;
  logic signed [63:0] perrin_value;
  logic out_valid;
  logic out_stall;

  perrin_expect_t perrin_pending[$];
  int errors = 0;
  int stuck_cycles = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  perrin_number_matrix_power_core #(
    .INDEX_BITS(IDX_W)
  ) dut (
    .clk(clk),
    .rst(rst),
    .index(index),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .perrin_value(perrin_value),
    .out_valid(out_valid),
    .out_stall(out_stall)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic mat3_t mat3_product(input mat3_t a, input mat3_t b);
    mat3_t c;
    word_t sum;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        sum = '0;
        for (int k = 0; k < 3; k++) sum += a[i][k] * b[k][j];
        c[i][j] = sum;
      end
    end
    return c;
  endfunction

  // P(n) mod 2^64: companion matrix to the power n-2, top row dotted with (2,0,3).
  function automatic word_t perrin_at(input idx_t n);
    mat3_t acc;
    mat3_t sq;
    word_t expo;
    if (n == 0) return P0;
    if (n == 1) return P1;
    if (n == 2) return P2;
    acc = '0;
    for (int i = 0; i < 3; i++) acc[i][i] = 64'd1;
    sq = '0;
    sq[0][1] = 64'd1;
    sq[0][2] = 64'd1;
    sq[1][0] = 64'd1;
    sq[2][1] = 64'd1;
    expo = word_t'(n) - 64'd2;
    for (int b = 0; b < IDX_W; b++) begin
      if (expo[b]) acc = mat3_product(acc, sq);
      sq = mat3_product(sq, sq);
    end
    return acc[0][0] * 64'd2 + acc[0][2] * 64'd3;
  endfunction

  // Mostly short indices keep the run short; a few use the full width.
  function automatic idx_t pick_index();
    int r;
    r = $urandom_range(99);
    if (r < 60) return idx_t'($urandom_range(10));
    if (r < 85) return idx_t'($urandom_range(66));
    if (r < 97) return idx_t'($urandom_range(4095));
    return idx_t'($urandom());
  endfunction

  task automatic send_index(input idx_t n);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    index <= n;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    perrin_pending.push_back('{n: n, value: perrin_at(n)});
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  task automatic test_small_indices();
    for (int n = 0; n <= 10; n++) send_index(idx_t'(n));
  endtask

  task automatic test_extremes();
    send_index(31'h7FFF_FFFF);
    send_index(31'h7FFF_FFFE);
    send_index(31'h4000_0000);
    send_index(31'h4000_0001);
    send_index(31'h4000_0002);
    send_index(31'h5555_5555);
    send_index(31'h2AAA_AAAA);
    send_index(31'h0000_0102);
    send_index(31'h0001_0001);
    // sit just past the first signed wrap of the sequence
    send_index(idx_t'(157));
    send_index(idx_t'(158));
    send_index(idx_t'(200));
  endtask

  task automatic test_random_indices(input int count);
    for (int i = 0; i < count; i++) send_index(pick_index());
  endtask

  task automatic test_pause_until_drained();
    for (int i = 0; i < 8; i++) send_index(pick_index());
    in_valid <= 1'b0;
    do @(posedge clk); while (perrin_pending.size() != 0);
    for (int i = 0; i < 8; i++) send_index(pick_index());
  endtask

  initial begin
    rst = 1'b1;
    index = '0;
    in_valid = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    set_idling(36, 67);
    test_small_indices();
    test_extremes();
    test_random_indices(570);
    test_pause_until_drained();
    set_idling(67, 36);
    test_random_indices(570);
    set_idling(0, 0);
    test_random_indices(570);

    in_valid <= 1'b0;
    do @(posedge clk); while (perrin_pending.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0 && perrin_pending.size() == 0) begin
      $display("tb_perrin_number_matrix_power_core: done, clean");
    end else begin
      $display("tb_perrin_number_matrix_power_core: done, errors");
    end
    $finish;
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    perrin_expect_t want;
    if (!rst && out_valid && !out_stall) begin
      if (perrin_pending.size() == 0) begin
        if (errors < MAX_REPORTS)
          $display("unexpected word perrin_value=%0d with nothing pending", perrin_value);
        errors++;
      end else begin
        want = perrin_pending.pop_front();
        if (word_t'(perrin_value) !== want.value) begin
          if (errors < MAX_REPORTS)
            $display("index %0d: perrin_value expected %0d, got %0d",
                     want.n, $signed(want.value), perrin_value);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("stalled for %0d cycles with %0d words pending",
                 stuck_cycles, perrin_pending.size());
        $display("tb_perrin_number_matrix_power_core: done, errors");
        $finish;
      end
    end
  end

endmodule

// ----- filelist.f -----
rtl/pnmp_pkg.sv
rtl/pnmp_seq.sv
rtl/pnmp_matmul.sv
rtl/perrin_number_matrix_power_core.sv
rtl/pnmp_checker.sv
bench/tb_perrin_number_matrix_power_core.sv
